FILE: src/tlg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_pkg: shared types and constants of the toroidal life block
// control word layout, microcode program, item codes and the b3/s23 rule mask
// ----------------------------------------------------------------------------
package tlg_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    localparam int MODE_W     = 2;
    localparam int ELAPSED_W  = 16;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 6;
    localparam int PERIOD_W   = 16;
    localparam int ACC_W      = 32;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 16'd100;
    localparam logic [APB_ADDR_W-1:0] ADDR_PERIOD  = 2'd0;

    // next state by live neighbour count, bit 0 for a dead cell, bit 1 for a live one
    localparam logic [1:0] RULE_MASK [9] = '{2'd0, 2'd0, 2'd2, 2'd3, 2'd0,
                                             2'd0, 2'd0, 2'd0, 2'd0};

    typedef enum logic [MODE_W-1:0] {
        MODE_TIME  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_TIME  = 4'd1,
        ST_TCHK  = 4'd2,
        ST_G0    = 4'd3,
        ST_G1    = 4'd4,
        ST_G2    = 4'd5,
        ST_GL0   = 4'd6,
        ST_GL1   = 4'd7,
        ST_GEND  = 4'd8,
        ST_WR0   = 4'd9,
        ST_WR1   = 4'd10,
        ST_RD0   = 4'd11,
        ST_RD1   = 4'd12,
        ST_CLR0  = 4'd13,
        ST_CLR1  = 4'd14,
        ST_DONE  = 4'd15
    } step_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_LAST, ROW_Y, ROW_YNEXT} row_src_t;
    typedef enum logic [1:0] {BANK_CUR, BANK_OTHER, BANK_ZERO, BANK_ONE} bank_src_t;
    typedef enum logic [1:0] {WR_NONE, WR_GEN, WR_CELL, WR_ZERO} wr_op_t;
    typedef enum logic [1:0] {LD_NONE, LD_PREV, LD_CUR, LD_SHIFT} ld_op_t;
    typedef enum logic [1:0] {CNT_HOLD, CNT_ZERO, CNT_STEP} cnt_op_t;
    typedef enum logic [1:0] {ACC_NONE, ACC_ADD, ACC_SUB} acc_op_t;
    typedef enum logic [2:0] {JMP_NONE, JMP_ALWAYS, JMP_START, JMP_NOT_LAST, JMP_IF_LT} jmp_t;

    typedef struct packed {
        logic      rd;
        row_src_t  row_src;
        bank_src_t bank_src;
        wr_op_t    wr;
        ld_op_t    ld;
        cnt_op_t   cnt;
        acc_op_t   acc;
        jmp_t      jmp;
        step_t     target;
        logic      swap;
        logic      set_adv;
        logic      set_cs;
        logic      done;
    } ucw_t;

    // microcode rom
    function automatic ucw_t ucode(input step_t s);
        ucw_t w;
        w = '0;
        unique case (s)
            ST_IDLE:
            begin
                w.cnt = CNT_ZERO;
                w.jmp = JMP_START;
            end
            ST_TIME:
            begin
                w.acc = ACC_ADD;
            end
            ST_TCHK:
            begin
                w.acc    = ACC_SUB;
                w.jmp    = JMP_IF_LT;
                w.target = ST_DONE;
            end
            ST_G0:
            begin
                w.rd       = 1'b1;
                w.row_src  = ROW_LAST;
                w.bank_src = BANK_CUR;
            end
            ST_G1:
            begin
                w.ld       = LD_PREV;
                w.rd       = 1'b1;
                w.row_src  = ROW_Y;
                w.bank_src = BANK_CUR;
            end
            ST_G2:
            begin
                w.ld = LD_CUR;
            end
            ST_GL0:
            begin
                w.rd       = 1'b1;
                w.row_src  = ROW_YNEXT;
                w.bank_src = BANK_CUR;
            end
            ST_GL1:
            begin
                w.wr       = WR_GEN;
                w.row_src  = ROW_Y;
                w.bank_src = BANK_OTHER;
                w.ld       = LD_SHIFT;
                w.cnt      = CNT_STEP;
                w.jmp      = JMP_NOT_LAST;
                w.target   = ST_GL0;
            end
            ST_GEND:
            begin
                w.swap    = 1'b1;
                w.set_adv = 1'b1;
                w.jmp     = JMP_ALWAYS;
                w.target  = ST_DONE;
            end
            ST_WR0:
            begin
                w.rd       = 1'b1;
                w.row_src  = ROW_ITEM;
                w.bank_src = BANK_CUR;
            end
            ST_WR1:
            begin
                w.wr       = WR_CELL;
                w.row_src  = ROW_ITEM;
                w.bank_src = BANK_CUR;
                w.jmp      = JMP_ALWAYS;
                w.target   = ST_DONE;
            end
            ST_RD0:
            begin
                w.rd       = 1'b1;
                w.row_src  = ROW_ITEM;
                w.bank_src = BANK_CUR;
            end
            ST_RD1:
            begin
                w.set_cs = 1'b1;
                w.jmp    = JMP_ALWAYS;
                w.target = ST_DONE;
            end
            ST_CLR0:
            begin
                w.wr       = WR_ZERO;
                w.row_src  = ROW_Y;
                w.bank_src = BANK_ZERO;
                w.cnt      = CNT_STEP;
                w.jmp      = JMP_NOT_LAST;
                w.target   = ST_CLR0;
            end
            ST_CLR1:
            begin
                w.wr       = WR_ZERO;
                w.row_src  = ROW_Y;
                w.bank_src = BANK_ONE;
                w.cnt      = CNT_STEP;
                w.jmp      = JMP_NOT_LAST;
                w.target   = ST_CLR1;
            end
            ST_DONE:
            begin
                w.done   = 1'b1;
                w.jmp    = JMP_ALWAYS;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.jmp    = JMP_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // entry point of each transaction kind
    function automatic step_t dispatch(input logic [MODE_W-1:0] m);
        step_t s;
        s = ST_IDLE;
        unique case (m)
            MODE_TIME:  s = ST_TIME;
            MODE_WRITE: s = ST_WR0;
            MODE_READ:  s = ST_RD0;
            MODE_CLEAR: s = ST_CLR0;
            default:    s = ST_IDLE;
        endcase
        return s;
    endfunction

endpackage

FILE: src/tlg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_ram: generic single-write, single-read ram
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module tlg_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/tlg_row_rule.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_row_rule: next generation of one grid row
// counts the eight wrapped neighbours of every cell and applies b3/s23
// ----------------------------------------------------------------------------
module tlg_row_rule #(
    parameter int W = 64
) (
    input  logic [W-1:0] prev_row,
    input  logic [W-1:0] cur_row,
    input  logic [W-1:0] next_row,
    output logic [W-1:0] new_row
);

    import tlg_pkg::*;

    for (genvar x = 0; x < W; x++)
    begin : g_cell
        localparam int XL = (x == 0) ? W - 1 : x - 1;
        localparam int XR = (x == W - 1) ? 0 : x + 1;
        logic [3:0] cnt;

        always_comb
        begin
            cnt = 4'(prev_row[XL]) + 4'(prev_row[x]) + 4'(prev_row[XR])
                + 4'(cur_row[XL])                    + 4'(cur_row[XR])
                + 4'(next_row[XL]) + 4'(next_row[x]) + 4'(next_row[XR]);
            new_row[x] = RULE_MASK[cnt][cur_row[x]];
        end
    end

endmodule

FILE: src/toroidal_life_generation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_generation: conway life (b3/s23) on a wrapped grid
// two cell banks, tick accumulator and a microcoded row sequencer
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single result
// appears on cell_state and advanced for exactly one cycle with done high, and
// the receiver cannot hold it off. Mode 0 adds elapsed to a saturating 32-bit
// accumulator and, if it reached generation_period, subtracts the period and
// computes one generation (advanced = 1). Mode 1 writes a cell, mode 2 reads a
// cell (out-of-grid addresses are ignored / read as dead), mode 3 clears both
// banks. The grid is kept one row per memory word, so the sequencer handles a
// whole row per step pair in the generation loop (one memory read and one row
// write per row) and per single step in the clear loop. After reset busy stays
// high while both banks are swept to dead; configuration writes are taken at
// any time and generation_period (apb register 0) should only be changed while
// the block is idle.
// ----------------------------------------------------------------------------
module toroidal_life_generation #(
    parameter int GRID_WIDTH  = tlg_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = tlg_pkg::GRID_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tlg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tlg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // command side
    input  logic                            start,
    output logic                            busy,
    input  logic [tlg_pkg::MODE_W-1:0]      mode,
    input  logic [tlg_pkg::ELAPSED_W-1:0]   elapsed,
    input  logic [tlg_pkg::COL_W-1:0]       col,
    input  logic [tlg_pkg::ROW_W-1:0]       row,
    input  logic                            value,
    // result side
    output logic                            done,
    output logic                            cell_state,
    output logic                            advanced
);

    import tlg_pkg::*;

    localparam int CW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int DEPTH = 2 * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    // item coordinates widened so the grid size itself fits for the bounds check
    localparam int CXW   = ($clog2(GRID_WIDTH + 1) > COL_W) ? $clog2(GRID_WIDTH + 1) : COL_W;
    localparam int RXW   = ($clog2(GRID_HEIGHT + 1) > ROW_W) ? $clog2(GRID_HEIGHT + 1) : ROW_W;

    localparam logic [YW-1:0] ROW_LAST_IDX = YW'(GRID_HEIGHT - 1);
    localparam logic [AW-1:0] BANK_OFS     = AW'(GRID_HEIGHT);

    // sequencer state
    step_t                 pc_reg, pc_next;
    ucw_t                  uc;
    logic                  pending_reg, pending_next;
    logic [YW-1:0]         y_reg, y_next;
    logic [YW-1:0]         y_wrap;
    logic                  y_last;

    // architectural state
    logic                  bank_sel_reg, bank_sel_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;

    // latched transaction
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic                  value_reg, value_next;
    logic                  inside_reg, inside_next;
    logic [CW-1:0]         col_idx_reg, col_idx_next;
    logic [YW-1:0]         row_idx_reg, row_idx_next;

    // result flags and result port registers
    logic                  adv_flag_reg, adv_flag_next;
    logic                  cs_flag_reg, cs_flag_next;
    logic                  done_reg, done_next;
    logic                  cell_state_reg, cell_state_next;
    logic                  advanced_reg, advanced_next;

    // row window for the generation loop
    logic [GRID_WIDTH-1:0] prev_row_reg, prev_row_next;
    logic [GRID_WIDTH-1:0] cur_row_reg, cur_row_next;
    logic [GRID_WIDTH-1:0] gen_row;
    logic [GRID_WIDTH-1:0] rmw_row;

    // memory port
    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_addr;
    logic [GRID_WIDTH-1:0] ram_wdata;
    logic [GRID_WIDTH-1:0] ram_rdata;

    // datapath helpers
    logic                  accept;
    logic                  cfg_write;
    logic [CXW-1:0]        col_ext;
    logic [RXW-1:0]        row_ext;
    logic                  item_inside;
    logic [ACC_W:0]        acc_sum;
    logic                  acc_ge;
    logic [YW-1:0]         row_sel;
    logic                  bank_bit;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign busy      = (pc_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_PERIOD) ? APB_DATA_W'(period_reg) : '0;

    assign done       = done_reg;
    assign cell_state = cell_state_reg;
    assign advanced   = advanced_reg;

    // current control word
    assign uc = ucode(pc_reg);

    // ------------------------------------------------------------------
    // transaction decode: bounds check against the grid size
    // ------------------------------------------------------------------
    assign col_ext     = CXW'(col);
    assign row_ext     = RXW'(row);
    assign item_inside = (col_ext < CXW'(GRID_WIDTH)) && (row_ext < RXW'(GRID_HEIGHT));

    // ------------------------------------------------------------------
    // row counter with torus wrap
    // ------------------------------------------------------------------
    assign y_last = (y_reg == ROW_LAST_IDX);
    assign y_wrap = y_last ? '0 : y_reg + YW'(1);

    // ------------------------------------------------------------------
    // accumulator: saturating add, compare against the period
    // ------------------------------------------------------------------
    assign acc_sum = {1'b0, acc_reg} + (ACC_W + 1)'(elapsed_reg);
    assign acc_ge  = (acc_reg >= ACC_W'(period_reg));

    // ------------------------------------------------------------------
    // memory address: bank 0 occupies rows 0..H-1, bank 1 rows H..2H-1
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (uc.row_src)
            ROW_ITEM:  row_sel = row_idx_reg;
            ROW_LAST:  row_sel = ROW_LAST_IDX;
            ROW_Y:     row_sel = y_reg;
            ROW_YNEXT: row_sel = y_wrap;
            default:   row_sel = y_reg;
        endcase
        unique case (uc.bank_src)
            BANK_CUR:   bank_bit = bank_sel_reg;
            BANK_OTHER: bank_bit = ~bank_sel_reg;
            BANK_ZERO:  bank_bit = 1'b0;
            BANK_ONE:   bank_bit = 1'b1;
            default:    bank_bit = bank_sel_reg;
        endcase
        ram_addr = bank_bit ? (AW'(row_sel) + BANK_OFS) : AW'(row_sel);
    end

    // read-modify-write row for a single cell update
    always_comb
    begin
        rmw_row              = ram_rdata;
        rmw_row[col_idx_reg] = value_reg;
    end

    // write data and enable; a cell write outside the grid is dropped
    always_comb
    begin
        unique case (uc.wr)
            WR_GEN:  ram_wdata = gen_row;
            WR_CELL: ram_wdata = rmw_row;
            WR_ZERO: ram_wdata = '0;
            default: ram_wdata = '0;
        endcase
        ram_we = (uc.wr != WR_NONE) && ((uc.wr != WR_CELL) || inside_reg);
        ram_re = uc.rd;
    end

    tlg_ram #(
        .DATA_W (GRID_WIDTH),
        .DEPTH  (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // next row from prev / cur window and the row just read
    tlg_row_rule #(
        .W (GRID_WIDTH)
    ) u_rule (
        .prev_row (prev_row_reg),
        .cur_row  (cur_row_reg),
        .next_row (ram_rdata),
        .new_row  (gen_row)
    );

    // ------------------------------------------------------------------
    // sequencer and datapath next state
    // ------------------------------------------------------------------
    always_comb
    begin
        pc_next         = pc_reg;
        pending_next    = pending_reg;
        y_next          = y_reg;
        bank_sel_next   = bank_sel_reg;
        acc_next        = acc_reg;
        period_next     = period_reg;
        elapsed_next    = elapsed_reg;
        value_next      = value_reg;
        inside_next     = inside_reg;
        col_idx_next    = col_idx_reg;
        row_idx_next    = row_idx_reg;
        adv_flag_next   = adv_flag_reg;
        cs_flag_next    = cs_flag_reg;
        done_next       = 1'b0;
        cell_state_next = cell_state_reg;
        advanced_next   = advanced_reg;
        prev_row_next   = prev_row_reg;
        cur_row_next    = cur_row_reg;

        // configuration
        if (cfg_write && (paddr == ADDR_PERIOD))
        begin
            period_next = pwdata[PERIOD_W-1:0];
        end

        // latch a new transaction
        if (accept)
        begin
            pending_next  = 1'b1;
            elapsed_next  = elapsed;
            value_next    = value;
            inside_next   = item_inside;
            col_idx_next  = col_ext[CW-1:0];
            row_idx_next  = row_ext[YW-1:0];
            adv_flag_next = 1'b0;
            cs_flag_next  = 1'b0;
        end

        // row counter
        unique case (uc.cnt)
            CNT_ZERO: y_next = '0;
            CNT_STEP: y_next = y_wrap;
            default:  y_next = y_reg;
        endcase

        // row window loads
        unique case (uc.ld)
            LD_PREV:  prev_row_next = ram_rdata;
            LD_CUR:   cur_row_next  = ram_rdata;
            LD_SHIFT:
            begin
                prev_row_next = cur_row_reg;
                cur_row_next  = ram_rdata;
            end
            default:  ;
        endcase

        // accumulator
        unique case (uc.acc)
            ACC_ADD:  acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
            ACC_SUB:
            begin
                if (acc_ge)
                begin
                    acc_next = acc_reg - ACC_W'(period_reg);
                end
            end
            default:  ;
        endcase

        if (uc.swap)
        begin
            bank_sel_next = ~bank_sel_reg;
        end
        if (uc.set_adv)
        begin
            adv_flag_next = 1'b1;
        end
        if (uc.set_cs)
        begin
            cs_flag_next = inside_reg && ram_rdata[col_idx_reg];
        end

        // result: only for a transaction, not for the power-on sweep
        if (uc.done)
        begin
            done_next       = pending_reg;
            pending_next    = 1'b0;
            cell_state_next = cs_flag_reg;
            advanced_next   = adv_flag_reg;
        end

        // program counter
        unique case (uc.jmp)
            JMP_ALWAYS:   pc_next = uc.target;
            JMP_START:    pc_next = start ? dispatch(mode) : pc_reg;
            JMP_NOT_LAST: pc_next = y_last ? step_t'(pc_reg + 4'd1) : uc.target;
            JMP_IF_LT:    pc_next = acc_ge ? step_t'(pc_reg + 4'd1) : uc.target;
            default:      pc_next = step_t'(pc_reg + 4'd1);
        endcase
    end

    // control registers; reset enters the bank clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= ST_CLR0;
            pending_reg  <= 1'b0;
            y_reg        <= '0;
            bank_sel_reg <= 1'b0;
            acc_reg      <= '0;
            period_reg   <= PERIOD_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            pc_reg       <= pc_next;
            pending_reg  <= pending_next;
            y_reg        <= y_next;
            bank_sel_reg <= bank_sel_next;
            acc_reg      <= acc_next;
            period_reg   <= period_next;
            done_reg     <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        elapsed_reg    <= elapsed_next;
        value_reg      <= value_next;
        inside_reg     <= inside_next;
        col_idx_reg    <= col_idx_next;
        row_idx_reg    <= row_idx_next;
        adv_flag_reg   <= adv_flag_next;
        cs_flag_reg    <= cs_flag_next;
        cell_state_reg <= cell_state_next;
        advanced_reg   <= advanced_next;
        prev_row_reg   <= prev_row_next;
        cur_row_reg    <= cur_row_next;
    end

endmodule
